// File: rtl/i2p_pkg.sv
`timescale 1ns / 1ps

package i2p_pkg;

	localparam int STACK_DEPTH_DEFAULT = 16;

	localparam int PREC_W  = 18;
	localparam int ASSOC_W = 6;
	localparam int CFG_W   = 18;
	localparam int CFG_IDX_W = 2;

	localparam logic [PREC_W-1:0]  PREC_RESET  = 18'd144521;
	localparam logic [ASSOC_W-1:0] ASSOC_RESET = 6'd16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PREC  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ASSOC = 2'd1;

	// token kinds on the input
	localparam logic [2:0] MODE_NUM   = 3'd0;
	localparam logic [2:0] MODE_OPEN  = 3'd1;
	localparam logic [2:0] MODE_CLOSE = 3'd2;
	localparam logic [2:0] MODE_OP    = 3'd3;
	localparam logic [2:0] MODE_END   = 3'd4;

	// operator codes
	localparam logic [2:0] OP_PLUS  = 3'd0;
	localparam logic [2:0] OP_MINUS = 3'd1;
	localparam logic [2:0] OP_TIMES = 3'd2;
	localparam logic [2:0] OP_DIV   = 3'd3;
	localparam logic [2:0] OP_POW   = 3'd4;
	localparam logic [2:0] OP_BANG  = 3'd5;
	localparam logic [2:0] OPEN_MARK = 3'd7;

	// result kinds
	localparam logic [1:0] KIND_NUM = 2'd0;
	localparam logic [1:0] KIND_OP  = 2'd1;
	localparam logic [1:0] KIND_END = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_CLOSE    = 2'd1;
	localparam logic [1:0] ERR_OPEN     = 2'd2;
	localparam logic [1:0] ERR_OVERFLOW = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_CHECK,
		ST_SETTLE,
		ST_END_MARK,
		ST_FINISH
	} ctrl_state_t;

	typedef enum logic [1:0] {
		SEL_NUM,
		SEL_TOP,
		SEL_END
	} emit_sel_t;

	typedef struct packed {
		logic       latch;
		logic       push;
		logic       push_open;
		logic       pop;
		logic       emit;
		emit_sel_t  sel;
		logic       finish;
		logic       note;
		logic [1:0] note_code;
		logic       clear_end;
	} cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       code_ok;
		logic       count_zero;
		logic       top_open;
		logic       pop_cond;
		logic       hold_valid;
		logic       out_free;
	} status_t;

	function automatic logic [2:0] prec_of(logic [PREC_W-1:0] tbl, logic [2:0] code);
		logic [2:0] p;
		case (code)
			OP_PLUS:  p = tbl[2:0];
			OP_MINUS: p = tbl[5:3];
			OP_TIMES: p = tbl[8:6];
			OP_DIV:   p = tbl[11:9];
			OP_POW:   p = tbl[14:12];
			OP_BANG:  p = tbl[17:15];
			default:  p = 3'd0;
		endcase
		return p;
	endfunction

endpackage

// File: rtl/i2p_token_if.sv
`timescale 1ns / 1ps

interface i2p_token_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic [2:0]         operator_code;
	logic signed [31:0] number_value;

	modport source(output valid, output mode, output operator_code, output number_value,
		input ready);
	modport sink(input valid, input mode, input operator_code, input number_value,
		output ready);
endinterface

// File: rtl/i2p_result_if.sv
`timescale 1ns / 1ps

interface i2p_result_if;
	logic               valid;
	logic               ready;
	logic [1:0]         out_kind;
	logic [2:0]         out_operator;
	logic signed [31:0] out_value;
	logic               is_last;
	logic [1:0]         error_code;

	modport source(output valid, output out_kind, output out_operator, output out_value,
		output is_last, output error_code, input ready);
	modport sink(input valid, input out_kind, input out_operator, input out_value,
		input is_last, input error_code, output ready);
endinterface

// File: rtl/i2p_ctrl.sv
`timescale 1ns / 1ps

module i2p_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  i2p_pkg::status_t st,
	output i2p_pkg::cmd_t    cmd
);
	import i2p_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        can_emit;

	// a new result can go to the hold stage if the hold stage is empty or can drain
	assign can_emit = !st.hold_valid || st.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.sel  = SEL_NUM;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (st.mode)
					MODE_NUM: begin
						if (can_emit) begin
							cmd.emit = 1'b1;
							cmd.sel  = SEL_NUM;
							state_d  = ST_FINISH;
						end
					end
					MODE_OPEN: begin
						cmd.push      = 1'b1;
						cmd.push_open = 1'b1;
						state_d       = ST_FINISH;
					end
					MODE_OP: begin
						state_d = st.code_ok ? ST_CHECK : ST_IDLE;
					end
					MODE_CLOSE, MODE_END: begin
						state_d = ST_CHECK;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_CHECK: begin
				case (st.mode)
					MODE_CLOSE: begin
						if (st.count_zero) begin
							cmd.note      = 1'b1;
							cmd.note_code = ERR_CLOSE;
							state_d       = ST_FINISH;
						end else if (st.top_open) begin
							cmd.pop = 1'b1;
							state_d = ST_FINISH;
						end else if (can_emit) begin
							cmd.pop  = 1'b1;
							cmd.emit = 1'b1;
							cmd.sel  = SEL_TOP;
							state_d  = ST_SETTLE;
						end
					end
					MODE_OP: begin
						if (!st.count_zero && !st.top_open && st.pop_cond) begin
							if (can_emit) begin
								cmd.pop  = 1'b1;
								cmd.emit = 1'b1;
								cmd.sel  = SEL_TOP;
								state_d  = ST_SETTLE;
							end
						end else begin
							cmd.push = 1'b1;
							state_d  = ST_FINISH;
						end
					end
					MODE_END: begin
						if (st.count_zero) begin
							state_d = ST_END_MARK;
						end else if (st.top_open) begin
							cmd.pop       = 1'b1;
							cmd.note      = 1'b1;
							cmd.note_code = ERR_OPEN;
							state_d       = ST_SETTLE;
						end else if (can_emit) begin
							cmd.pop  = 1'b1;
							cmd.emit = 1'b1;
							cmd.sel  = SEL_TOP;
							state_d  = ST_SETTLE;
						end
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_SETTLE: begin
				// the stack read port is registered: wait here until it presents the new top
				state_d = ST_CHECK;
			end
			ST_END_MARK: begin
				if (can_emit) begin
					cmd.emit      = 1'b1;
					cmd.sel       = SEL_END;
					cmd.clear_end = 1'b1;
					state_d       = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!st.hold_valid) begin
					state_d = ST_IDLE;
				end else if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/i2p_datapath.sv
`timescale 1ns / 1ps

module i2p_datapath #(
	parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [i2p_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [i2p_pkg::CFG_W-1:0]        cfg_data,
	input  logic [2:0]                       in_mode,
	input  logic [2:0]                       in_operator_code,
	input  logic signed [31:0]               in_number_value,
	input  i2p_pkg::cmd_t                    cmd,
	output i2p_pkg::status_t                 st,
	input  logic                             res_ready,
	output logic                             res_valid,
	output logic [1:0]                       res_kind,
	output logic [2:0]                       res_operator,
	output logic signed [31:0]               res_value,
	output logic                             res_last,
	output logic [1:0]                       res_error
);
	import i2p_pkg::*;

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = $clog2(STACK_DEPTH);

	// configuration
	logic [PREC_W-1:0]  prec_q;
	logic [ASSOC_W-1:0] assoc_q;

	// current token
	logic [2:0]         mode_q;
	logic [2:0]         code_q;
	logic signed [31:0] number_q;

	// operator stack
	logic [2:0]       stack_mem [STACK_DEPTH];
	logic [2:0]       top_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_dec;
	logic [IDX_W-1:0] rd_addr;
	logic             full;
	logic [1:0]       sticky_q;

	// hold stage: last result is kept until it is known whether more follow
	logic               hold_valid_q;
	logic [1:0]         hold_kind_q;
	logic [2:0]         hold_op_q;
	logic signed [31:0] hold_value_q;
	logic [1:0]         hold_err_q;

	logic               out_valid_q;
	logic [1:0]         out_kind_q;
	logic [2:0]         out_op_q;
	logic signed [31:0] out_value_q;
	logic               out_last_q;
	logic [1:0]         out_err_q;

	logic       out_free;
	logic       load_out;
	logic [2:0] p_in;
	logic [2:0] p_top;
	logic [7:0] assoc_ext;
	logic       left_assoc;

	assign count_dec = count_q - CNT_W'(1);
	assign rd_addr   = (count_q == '0) ? '0 : count_dec[IDX_W-1:0];
	assign full      = (count_q == CNT_W'(STACK_DEPTH));

	assign assoc_ext  = {2'b00, assoc_q};
	assign left_assoc = !assoc_ext[code_q];
	assign p_in       = prec_of(prec_q, code_q);
	assign p_top      = prec_of(prec_q, top_q);

	assign out_free = !out_valid_q || res_ready;
	assign load_out = cmd.finish || (cmd.emit && hold_valid_q);

	always_comb begin
		st.mode       = mode_q;
		st.code_ok    = (code_q <= OP_BANG);
		st.count_zero = (count_q == '0);
		st.top_open   = (top_q == OPEN_MARK);
		st.pop_cond   = (p_top > p_in) || ((p_top == p_in) && left_assoc);
		st.hold_valid = hold_valid_q;
		st.out_free   = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prec_q  <= PREC_RESET;
			assoc_q <= ASSOC_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_PREC) begin
				prec_q <= cfg_data[PREC_W-1:0];
			end else if (cfg_index == REG_ASSOC) begin
				assoc_q <= cfg_data[ASSOC_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q   <= in_mode;
			code_q   <= in_operator_code;
			number_q <= in_number_value;
		end
	end

	// stack storage: one write port, one registered read of the top entry
	always_ff @(posedge clk) begin
		if (cmd.push && !full) begin
			stack_mem[count_q[IDX_W-1:0]] <= cmd.push_open ? OPEN_MARK : code_q;
		end
		top_q <= stack_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			sticky_q <= ERR_NONE;
		end else begin
			if (cmd.clear_end) begin
				count_q <= '0;
			end else if (cmd.pop) begin
				count_q <= count_dec;
			end else if (cmd.push && !full) begin
				count_q <= count_q + CNT_W'(1);
			end

			if (cmd.clear_end) begin
				sticky_q <= ERR_NONE;
			end else if (sticky_q == ERR_NONE) begin
				if (cmd.note) begin
					sticky_q <= cmd.note_code;
				end else if (cmd.push && full) begin
					sticky_q <= ERR_OVERFLOW;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.emit) begin
				hold_valid_q <= 1'b1;
			end else if (cmd.finish) begin
				hold_valid_q <= 1'b0;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.sel)
				SEL_NUM: begin
					hold_kind_q  <= KIND_NUM;
					hold_op_q    <= 3'd0;
					hold_value_q <= number_q;
					hold_err_q   <= ERR_NONE;
				end
				SEL_TOP: begin
					hold_kind_q  <= KIND_OP;
					hold_op_q    <= top_q;
					hold_value_q <= '0;
					hold_err_q   <= ERR_NONE;
				end
				SEL_END: begin
					hold_kind_q  <= KIND_END;
					hold_op_q    <= 3'd0;
					hold_value_q <= '0;
					hold_err_q   <= sticky_q;
				end
				default: begin
					hold_kind_q  <= KIND_NUM;
					hold_op_q    <= 3'd0;
					hold_value_q <= '0;
					hold_err_q   <= ERR_NONE;
				end
			endcase
		end
		if (load_out) begin
			out_kind_q  <= hold_kind_q;
			out_op_q    <= hold_op_q;
			out_value_q <= hold_value_q;
			out_err_q   <= hold_err_q;
			out_last_q  <= cmd.finish;
		end
	end

	assign res_valid    = out_valid_q;
	assign res_kind     = out_kind_q;
	assign res_operator = out_op_q;
	assign res_value    = out_value_q;
	assign res_last     = out_last_q;
	assign res_error    = out_err_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("operator stack count beyond depth");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.sel == SEL_END) |=> (count_q == '0 && sticky_q == ERR_NONE))
		else $error("stack or error not cleared after end marker");

	a_overflow_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && full) |=> (sticky_q != ERR_NONE))
		else $error("push on full stack left no error");

	a_first_error_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(sticky_q != ERR_NONE && !cmd.clear_end) |=> $stable(sticky_q))
		else $error("sticky error overwritten");

	a_out_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> out_free)
		else $error("result register loaded while full and stalled");

endmodule

// File: rtl/infix_to_postfix_converter.sv
`timescale 1ns / 1ps

// Infix to postfix converter (shunting-yard). One token per tok transaction; postfix tokens
// leave on res, the last result of each token flagged with is_last, and an end token closes
// the expression with an end marker carrying the first error seen since the previous end.
// A number is passed on, an open parenthesis pushed; an operator pops what its precedence and
// associativity allow, then is pushed; a close parenthesis pops down to its open mark, an end
// token empties the stack; an operator with an unknown code is ignored. After each pop the new
// top comes from the stack memory's registered read port before the next compare. A stalled
// res side holds the block. The user must write precedence (index 0) and right associativity
// (index 1) through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce this.

module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [i2p_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [i2p_pkg::CFG_W-1:0]     cfg_data,
	i2p_token_if.sink                     tok,
	i2p_result_if.source                  res
);
	import i2p_pkg::*;

	cmd_t    cmd;
	status_t st;

	i2p_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (tok.valid),
		.in_ready (tok.ready),
		.st       (st),
		.cmd      (cmd)
	);

	i2p_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_mode          (tok.mode),
		.in_operator_code (tok.operator_code),
		.in_number_value  (tok.number_value),
		.cmd              (cmd),
		.st               (st),
		.res_ready        (res.ready),
		.res_valid        (res.valid),
		.res_kind         (res.out_kind),
		.res_operator     (res.out_operator),
		.res_value        (res.out_value),
		.res_last         (res.is_last),
		.res_error        (res.error_code)
	);

endmodule
